[rtl/owbm_pkg.sv]
// Package for the one-wire bus master: shared types, command and phase codes,
// register indexes and fixed slot timings. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package owbm_pkg;

    // command codes on the input beat
    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_RESET = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;
    localparam logic [1:0] CMD_READ  = 2'd3;

    // operation phases
    localparam logic [3:0] PH_IDLE      = 4'd0;
    localparam logic [3:0] PH_RST_LOW   = 4'd1;
    localparam logic [3:0] PH_RST_REC   = 4'd2;
    localparam logic [3:0] PH_PRES_WAIT = 4'd3;
    localparam logic [3:0] PH_PRES_LOW  = 4'd4;
    localparam logic [3:0] PH_W_LOW     = 4'd5;
    localparam logic [3:0] PH_W_HOLD    = 4'd6;
    localparam logic [3:0] PH_W_REC     = 4'd7;
    localparam logic [3:0] PH_R_LOW     = 4'd8;
    localparam logic [3:0] PH_R_WAIT    = 4'd9;
    localparam logic [3:0] PH_R_REC     = 4'd10;

    // register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_RESET_LOW   = 3'd0;
    localparam logic [2:0] REG_RESET_REC   = 3'd1;
    localparam logic [2:0] REG_PRES_WAIT   = 3'd2;
    localparam logic [2:0] REG_PRES_LOW    = 3'd3;
    localparam logic [2:0] REG_WRITE_LOW   = 3'd4;
    localparam logic [2:0] REG_WRITE_SLOT  = 3'd5;
    localparam logic [2:0] REG_READ_LOW    = 3'd6;
    localparam logic [2:0] REG_READ_SAMPLE = 3'd7;

    // fixed recovery lengths closing each slot
    localparam logic [11:0] WRITE_REC_TICKS = 12'd5;
    localparam logic [11:0] READ_REC_TICKS  = 12'd50;

    // depth of the queue between front and back
    localparam int QDEPTH = 2;

    // one classified tick
    typedef struct packed {
        logic       start_reset;
        logic       start_write;
        logic       start_read;
        logic [7:0] data_byte;
        logic       bus_level;
    } t_item;

    // one result beat
    typedef struct packed {
        logic       drive_low;
        logic       busy;
        logic       done;
        logic       presence_fail;
        logic [7:0] read_data;
        logic       read_valid;
    } t_result;

    // timing registers
    typedef struct packed {
        logic [11:0] reset_low_time;
        logic [7:0]  reset_recovery_time;
        logic [7:0]  presence_wait_limit;
        logic [7:0]  presence_low_limit;
        logic [7:0]  write_low_time;
        logic [7:0]  write_slot_time;
        logic [7:0]  read_low_time;
        logic [7:0]  read_sample_delay;
    } t_cfg;

endpackage

`default_nettype wire

[rtl/owbm_regs.sv]
// Timing register file behind the APB-style port.
// Depends on owbm_pkg for the register indexes and the t_cfg struct.
`timescale 1ns / 1ps
`default_nettype none

module owbm_regs (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [4:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic      [31:0]          prdata,
    output logic                      pready,
    output owbm_pkg::t_cfg            o_cfg
);

    owbm_pkg::t_cfg r_cfg;
    logic [2:0]     reg_idx;
    logic           wr_en;

    assign reg_idx = paddr[4:2];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    // register writes, reset to the standard timings
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reset_low_time      <= 12'd750;
            r_cfg.reset_recovery_time <= 8'd15;
            r_cfg.presence_wait_limit <= 8'd200;
            r_cfg.presence_low_limit  <= 8'd240;
            r_cfg.write_low_time      <= 8'd2;
            r_cfg.write_slot_time     <= 8'd55;
            r_cfg.read_low_time       <= 8'd3;
            r_cfg.read_sample_delay   <= 8'd6;
        end else if (wr_en) begin
            unique case (reg_idx)
                owbm_pkg::REG_RESET_LOW:   r_cfg.reset_low_time      <= pwdata[11:0];
                owbm_pkg::REG_RESET_REC:   r_cfg.reset_recovery_time <= pwdata[7:0];
                owbm_pkg::REG_PRES_WAIT:   r_cfg.presence_wait_limit <= pwdata[7:0];
                owbm_pkg::REG_PRES_LOW:    r_cfg.presence_low_limit  <= pwdata[7:0];
                owbm_pkg::REG_WRITE_LOW:   r_cfg.write_low_time      <= pwdata[7:0];
                owbm_pkg::REG_WRITE_SLOT:  r_cfg.write_slot_time     <= pwdata[7:0];
                owbm_pkg::REG_READ_LOW:    r_cfg.read_low_time       <= pwdata[7:0];
                owbm_pkg::REG_READ_SAMPLE: r_cfg.read_sample_delay   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        unique case (reg_idx)
            owbm_pkg::REG_RESET_LOW:   prdata = {20'd0, r_cfg.reset_low_time};
            owbm_pkg::REG_RESET_REC:   prdata = {24'd0, r_cfg.reset_recovery_time};
            owbm_pkg::REG_PRES_WAIT:   prdata = {24'd0, r_cfg.presence_wait_limit};
            owbm_pkg::REG_PRES_LOW:    prdata = {24'd0, r_cfg.presence_low_limit};
            owbm_pkg::REG_WRITE_LOW:   prdata = {24'd0, r_cfg.write_low_time};
            owbm_pkg::REG_WRITE_SLOT:  prdata = {24'd0, r_cfg.write_slot_time};
            owbm_pkg::REG_READ_LOW:    prdata = {24'd0, r_cfg.read_low_time};
            owbm_pkg::REG_READ_SAMPLE: prdata = {24'd0, r_cfg.read_sample_delay};
            default:                   prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

[rtl/owbm_front.sv]
// Front stage: takes input beats, decodes the command and registers the item.
// Depends on owbm_pkg for command codes and the t_item struct.
`timescale 1ns / 1ps
`default_nettype none

module owbm_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire logic [1:0]     i_cmd,
    input  wire logic [7:0]     i_data_byte,
    input  wire logic           i_bus_level,
    output logic                o_item_valid,
    input  wire logic           i_item_ready,
    output owbm_pkg::t_item     o_item
);

    logic            r_valid;
    owbm_pkg::t_item r_item;
    owbm_pkg::t_item dec_item;

    // stage can load when empty or when its item moves on this cycle
    assign o_in_ready   = ~r_valid | i_item_ready;
    assign o_item_valid = r_valid;
    assign o_item       = r_item;

    // command decode
    always_comb begin
        dec_item.start_reset = 1'b0;
        dec_item.start_write = 1'b0;
        dec_item.start_read  = 1'b0;
        dec_item.data_byte   = i_data_byte;
        dec_item.bus_level   = i_bus_level;
        unique case (i_cmd)
            owbm_pkg::CMD_NONE:  ;
            owbm_pkg::CMD_RESET: dec_item.start_reset = 1'b1;
            owbm_pkg::CMD_WRITE: dec_item.start_write = 1'b1;
            owbm_pkg::CMD_READ:  dec_item.start_read  = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_item <= dec_item;
        end
    end

endmodule

`default_nettype wire

[rtl/owbm_queue.sv]
// Short flop queue of classified items between front and back.
// Depends on owbm_pkg for t_item and the queue depth.
`timescale 1ns / 1ps
`default_nettype none

module owbm_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push_valid,
    output logic                o_push_ready,
    input  wire owbm_pkg::t_item i_push_item,
    output logic                o_pop_valid,
    input  wire logic           i_pop_ready,
    output owbm_pkg::t_item     o_pop_item
);

    localparam int PTR_W = (owbm_pkg::QDEPTH > 1) ? $clog2(owbm_pkg::QDEPTH) : 1;
    localparam logic [PTR_W-1:0] LAST = PTR_W'(owbm_pkg::QDEPTH - 1);

    owbm_pkg::t_item  r_mem [owbm_pkg::QDEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_count;
    logic             push;
    logic             pop;

    assign o_push_ready = (r_count != (PTR_W+1)'(owbm_pkg::QDEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_item   = r_mem[r_rd_ptr];
    assign push         = i_push_valid & o_push_ready;
    assign pop          = o_pop_valid & i_pop_ready;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

`default_nettype wire

[rtl/owbm_engine.sv]
// Back end: bus timing sequencer, one tick per item, with the result register.
// Depends on owbm_pkg for phase codes, slot timings and the shared structs.
`timescale 1ns / 1ps
`default_nettype none

module owbm_engine #(
    parameter int TIMER_BITS = 12
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire owbm_pkg::t_cfg i_cfg,
    input  wire logic           i_item_valid,
    output logic                o_item_ready,
    input  wire owbm_pkg::t_item i_item,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output owbm_pkg::t_result   o_res
);

    localparam int LW = 17;
    localparam logic [LW-1:0] TMASK = (LW'(1) << TIMER_BITS) - LW'(1);

    logic [3:0]            r_phase;
    logic [TIMER_BITS-1:0] r_timer;
    logic [7:0]            r_pcnt;
    logic [2:0]            r_bit;
    logic [7:0]            r_shift;
    logic                  r_out_valid;
    owbm_pkg::t_result     r_res;

    logic [3:0]            n_phase;
    logic [TIMER_BITS-1:0] n_timer;
    logic [7:0]            n_pcnt;
    logic [2:0]            n_bit;
    logic [7:0]            n_shift;
    owbm_pkg::t_result     n_res;

    // values after the idle dispatch
    logic [3:0]            c_phase;
    logic [TIMER_BITS-1:0] c_timer;
    logic [2:0]            c_bit;
    logic [7:0]            c_shift;
    logic [7:0]            smp_shift;

    logic [11:0]           dur;
    logic [LW-1:0]         dur_ext;
    logic [LW-1:0]         lim;
    logic [TIMER_BITS-1:0] t_inc;
    logic                  hit;
    logic                  pop;

    assign pop          = i_item_valid & (~r_out_valid | i_out_ready);
    assign o_item_ready = ~r_out_valid | i_out_ready;
    assign o_out_valid  = r_out_valid;
    assign o_res        = r_res;

    // idle: clear the timer and bit counters and start on a command
    always_comb begin
        c_phase = (r_phase > owbm_pkg::PH_R_REC) ? owbm_pkg::PH_IDLE : r_phase;
        c_timer = r_timer;
        c_bit   = r_bit;
        c_shift = r_shift;
        if (c_phase == owbm_pkg::PH_IDLE) begin
            c_timer = '0;
            c_bit   = '0;
            priority if (i_item.start_reset) begin
                c_phase = owbm_pkg::PH_RST_LOW;
            end else if (i_item.start_write) begin
                c_shift = i_item.data_byte;
                c_phase = owbm_pkg::PH_W_LOW;
            end else if (i_item.start_read) begin
                c_shift = 8'd0;
                c_phase = owbm_pkg::PH_R_LOW;
            end else begin
                // no command: stay idle
                c_phase = owbm_pkg::PH_IDLE;
            end
        end
    end

    // duration of the timed phase
    always_comb begin
        unique case (c_phase)
            owbm_pkg::PH_RST_LOW: dur = i_cfg.reset_low_time;
            owbm_pkg::PH_RST_REC: dur = {4'd0, i_cfg.reset_recovery_time};
            owbm_pkg::PH_W_LOW:   dur = {4'd0, i_cfg.write_low_time};
            owbm_pkg::PH_W_HOLD:  dur = {4'd0, i_cfg.write_slot_time};
            owbm_pkg::PH_W_REC:   dur = owbm_pkg::WRITE_REC_TICKS;
            owbm_pkg::PH_R_LOW:   dur = {4'd0, i_cfg.read_low_time};
            owbm_pkg::PH_R_WAIT:  dur = {4'd0, i_cfg.read_sample_delay};
            owbm_pkg::PH_R_REC:   dur = owbm_pkg::READ_REC_TICKS;
            default:              dur = 12'd1;
        endcase
    end

    // zero acts as one tick, long durations saturate to the timer range
    assign dur_ext = LW'(dur);
    assign lim     = (dur == 12'd0) ? LW'(1) : ((dur_ext > TMASK) ? TMASK : dur_ext);
    assign t_inc   = c_timer + 1'b1;
    assign hit     = (LW'(t_inc) >= lim);

    // sample on the first tick of read recovery
    assign smp_shift = (c_timer == '0) ? {i_item.bus_level, c_shift[7:1]} : c_shift;

    // phase sequencing
    always_comb begin
        n_phase = c_phase;
        n_timer = c_timer;
        n_pcnt  = r_pcnt;
        n_bit   = c_bit;
        n_shift = c_shift;
        n_res   = '0;
        unique case (c_phase)
            owbm_pkg::PH_RST_LOW: begin
                n_res.drive_low = 1'b1;
                n_timer = hit ? '0 : t_inc;
                if (hit) n_phase = owbm_pkg::PH_RST_REC;
            end
            owbm_pkg::PH_RST_REC: begin
                n_timer = hit ? '0 : t_inc;
                if (hit) begin
                    n_phase = owbm_pkg::PH_PRES_WAIT;
                    n_pcnt  = 8'd0;
                end
            end
            owbm_pkg::PH_PRES_WAIT: begin
                priority if (i_item.bus_level && r_pcnt < i_cfg.presence_wait_limit) begin
                    n_pcnt = r_pcnt + 8'd1;
                end else if (r_pcnt >= i_cfg.presence_wait_limit) begin
                    n_res.done          = 1'b1;
                    n_res.presence_fail = 1'b1;
                    n_phase             = owbm_pkg::PH_IDLE;
                end else begin
                    n_pcnt  = 8'd0;
                    n_phase = owbm_pkg::PH_PRES_LOW;
                end
            end
            owbm_pkg::PH_PRES_LOW: begin
                if (!i_item.bus_level && r_pcnt < i_cfg.presence_low_limit) begin
                    n_pcnt = r_pcnt + 8'd1;
                end else begin
                    n_res.done          = 1'b1;
                    n_res.presence_fail = (r_pcnt >= i_cfg.presence_low_limit);
                    n_phase             = owbm_pkg::PH_IDLE;
                end
            end
            owbm_pkg::PH_W_LOW: begin
                n_res.drive_low = 1'b1;
                n_timer = hit ? '0 : t_inc;
                if (hit) n_phase = owbm_pkg::PH_W_HOLD;
            end
            owbm_pkg::PH_W_HOLD: begin
                n_res.drive_low = ~c_shift[0];
                n_timer = hit ? '0 : t_inc;
                if (hit) n_phase = owbm_pkg::PH_W_REC;
            end
            owbm_pkg::PH_W_REC: begin
                n_timer = hit ? '0 : t_inc;
                if (hit) begin
                    n_shift = {1'b0, c_shift[7:1]};
                    if (c_bit == 3'd7) begin
                        n_res.done = 1'b1;
                        n_phase    = owbm_pkg::PH_IDLE;
                    end else begin
                        n_bit   = c_bit + 3'd1;
                        n_phase = owbm_pkg::PH_W_LOW;
                    end
                end
            end
            owbm_pkg::PH_R_LOW: begin
                n_res.drive_low = 1'b1;
                n_timer = hit ? '0 : t_inc;
                if (hit) n_phase = owbm_pkg::PH_R_WAIT;
            end
            owbm_pkg::PH_R_WAIT: begin
                n_timer = hit ? '0 : t_inc;
                if (hit) n_phase = owbm_pkg::PH_R_REC;
            end
            owbm_pkg::PH_R_REC: begin
                n_shift = smp_shift;
                n_timer = hit ? '0 : t_inc;
                if (hit) begin
                    if (c_bit == 3'd7) begin
                        n_res.done       = 1'b1;
                        n_res.read_valid = 1'b1;
                        n_res.read_data  = smp_shift;
                        n_phase          = owbm_pkg::PH_IDLE;
                    end else begin
                        n_bit   = c_bit + 3'd1;
                        n_phase = owbm_pkg::PH_R_LOW;
                    end
                end
            end
            default: ;
        endcase
        n_res.busy = (n_phase != owbm_pkg::PH_IDLE);
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= owbm_pkg::PH_IDLE;
            r_timer <= '0;
            r_pcnt  <= '0;
            r_bit   <= '0;
            r_shift <= '0;
        end else if (pop) begin
            r_phase <= n_phase;
            r_timer <= n_timer;
            r_pcnt  <= n_pcnt;
            r_bit   <= n_bit;
            r_shift <= n_shift;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (pop) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_res <= n_res;
        end
    end

    // checks
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.done) |-> !r_res.busy)
        else $error("done result still reports busy");

    a_rvalid_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.read_valid) |-> (r_res.done && !r_res.presence_fail))
        else $error("read_valid without a plain completion");

    a_fail_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.presence_fail) |-> r_res.done)
        else $error("presence_fail outside a completion");

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase <= owbm_pkg::PH_R_REC)
        else $error("phase out of range");

    a_idle_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && r_phase == owbm_pkg::PH_IDLE && !i_item.start_reset
         && !i_item.start_write && !i_item.start_read) |=> (!r_res.busy && !r_res.drive_low))
        else $error("idle tick without command left the bus active");

endmodule

`default_nettype wire

[rtl/one_wire_bus_master.sv]
// Top level of the one-wire bus master: register file, front stage, queue, sequencer.
// Depends on owbm_pkg, owbm_regs, owbm_front, owbm_queue and owbm_engine.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+---------------------------------------------
//  in       | i_in_valid / o_in_ready    | i_cmd, i_data_byte, i_bus_level
//  out      | o_out_valid / i_out_ready  | o_drive_low, o_busy_res, o_done_res,
//           |                            | o_presence_fail, o_read_data, o_read_valid
//  config   | psel, penable, pwrite      | paddr, pwdata, prdata, pready (always high)
//
// One item per clock sustained while the output is not stalled; each beat is registered in
// turn in the front register, a queue entry and the result register.
// Reset is synchronous, active low, and returns the timings to their standard values.
// A stalled output holds the result register; the two-entry queue and the front
// register absorb input beats until they fill, then o_in_ready drops.
`timescale 1ns / 1ps
`default_nettype none

module one_wire_bus_master #(
    parameter int TIMER_BITS = 12
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // tick input
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_bus_level,
    // result output
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_drive_low,
    output logic             o_busy_res,
    output logic             o_done_res,
    output logic             o_presence_fail,
    output logic [7:0]       o_read_data,
    output logic             o_read_valid
);

    owbm_pkg::t_cfg    cfg;
    owbm_pkg::t_item   f_item;
    owbm_pkg::t_item   q_item;
    owbm_pkg::t_result res;
    logic              f_valid;
    logic              f_ready;
    logic              q_valid;
    logic              q_ready;

    owbm_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    owbm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_cmd        (i_cmd),
        .i_data_byte  (i_data_byte),
        .i_bus_level  (i_bus_level),
        .o_item_valid (f_valid),
        .i_item_ready (f_ready),
        .o_item       (f_item)
    );

    owbm_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .o_push_ready (f_ready),
        .i_push_item  (f_item),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_item   (q_item)
    );

    owbm_engine #(
        .TIMER_BITS (TIMER_BITS)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_item_valid (q_valid),
        .o_item_ready (q_ready),
        .i_item       (q_item),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_res        (res)
    );

    assign o_drive_low     = res.drive_low;
    assign o_busy_res      = res.busy;
    assign o_done_res      = res.done;
    assign o_presence_fail = res.presence_fail;
    assign o_read_data     = res.read_data;
    assign o_read_valid    = res.read_valid;

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
// Self-checking bench for one_wire_bus_master: microsecond ticks in, one result beat out per
// tick, every beat compared with a cycle-true line predictor. Depends on owbm_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;

    localparam int CLK_HALF      = 4;
    localparam int STALL_LIMIT   = 2000;
    localparam int PRESSURE_HOLD = 80;
    localparam int ITEMS         = 1450;

    localparam owbm_pkg::t_cfg STD_TIMINGS =
        '{12'd750, 8'd15, 8'd200, 8'd240, 8'd2, 8'd55, 8'd3, 8'd6};
    localparam owbm_pkg::t_cfg ONE_TIMINGS =
        '{12'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1};
    localparam owbm_pkg::t_cfg LIM_TIMINGS =
        '{12'd1, 8'd1, 8'hFF, 8'hFF, 8'd1, 8'd1, 8'd1, 8'd1};

    // one microsecond tick as offered on the input channel
    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] data;
        logic       lvl;
    } t_bus_tick;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_cmd = owbm_pkg::CMD_NONE;
    logic [7:0]  i_data_byte = '0;
    logic        i_bus_level = 1'b1;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic        o_drive_low;
    logic        o_busy_res;
    logic        o_done_res;
    logic        o_presence_fail;
    logic [7:0]  o_read_data;
    logic        o_read_valid;

    one_wire_bus_master i_dut (
        .i_clk, .i_rst_n,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .i_in_valid, .o_in_ready, .i_cmd, .i_data_byte, .i_bus_level,
        .o_out_valid, .i_out_ready, .o_drive_low, .o_busy_res, .o_done_res,
        .o_presence_fail, .o_read_data, .o_read_valid
    );

    always #CLK_HALF i_clk = ~i_clk;

    // ticks waiting to be offered, and line results owed by the block
    t_bus_tick          ticks_to_send[$];
    owbm_pkg::t_result  tick_results_due[$];
    int                 ticks_queued = 0;
    int                 mismatches = 0;
    int                 beats_seen = 0;
    int                 quiet_cycles = 0;

    // predictor state and timings
    owbm_pkg::t_cfg line_cfg;
    logic [3:0]     line_phase;
    logic [11:0]    slot_timer;
    logic [7:0]     presence_run;
    logic [2:0]     bit_pos;
    logic [7:0]     shift_reg;

    // one tick of a timed phase; true when the phase has run out
    function automatic bit slot_elapsed(input logic [11:0] dur);
        logic [11:0] lim;
        lim = (dur == 0) ? 12'd1 : dur;
        slot_timer = slot_timer + 12'd1;
        if (slot_timer >= lim) begin
            slot_timer = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // line behaviour for one microsecond tick
    function automatic owbm_pkg::t_result advance_bus_tick(input logic [1:0] cmd,
                                                           input logic [7:0] data,
                                                           input logic lvl);
        owbm_pkg::t_result r;
        r = '0;
        if (line_phase == owbm_pkg::PH_IDLE) begin
            slot_timer = '0;
            bit_pos    = '0;
            case (cmd)
                owbm_pkg::CMD_RESET: line_phase = owbm_pkg::PH_RST_LOW;
                owbm_pkg::CMD_WRITE: begin
                    shift_reg  = data;
                    line_phase = owbm_pkg::PH_W_LOW;
                end
                owbm_pkg::CMD_READ: begin
                    shift_reg  = '0;
                    line_phase = owbm_pkg::PH_R_LOW;
                end
                default: ;
            endcase
        end
        case (line_phase)
            owbm_pkg::PH_RST_LOW: begin
                r.drive_low = 1'b1;
                if (slot_elapsed(line_cfg.reset_low_time)) line_phase = owbm_pkg::PH_RST_REC;
            end
            owbm_pkg::PH_RST_REC: begin
                if (slot_elapsed({4'd0, line_cfg.reset_recovery_time})) begin
                    line_phase   = owbm_pkg::PH_PRES_WAIT;
                    presence_run = '0;
                end
            end
            owbm_pkg::PH_PRES_WAIT: begin
                if (lvl && presence_run < line_cfg.presence_wait_limit) begin
                    presence_run = presence_run + 8'd1;
                end else if (presence_run >= line_cfg.presence_wait_limit) begin
                    r.done          = 1'b1;
                    r.presence_fail = 1'b1;
                    line_phase      = owbm_pkg::PH_IDLE;
                end else begin
                    presence_run = '0;
                    line_phase   = owbm_pkg::PH_PRES_LOW;
                end
            end
            owbm_pkg::PH_PRES_LOW: begin
                if (!lvl && presence_run < line_cfg.presence_low_limit) begin
                    presence_run = presence_run + 8'd1;
                end else begin
                    r.done          = 1'b1;
                    r.presence_fail = (presence_run >= line_cfg.presence_low_limit);
                    line_phase      = owbm_pkg::PH_IDLE;
                end
            end
            owbm_pkg::PH_W_LOW: begin
                r.drive_low = 1'b1;
                if (slot_elapsed({4'd0, line_cfg.write_low_time}))
                    line_phase = owbm_pkg::PH_W_HOLD;
            end
            owbm_pkg::PH_W_HOLD: begin
                r.drive_low = ~shift_reg[0];
                if (slot_elapsed({4'd0, line_cfg.write_slot_time}))
                    line_phase = owbm_pkg::PH_W_REC;
            end
            owbm_pkg::PH_W_REC: begin
                if (slot_elapsed(owbm_pkg::WRITE_REC_TICKS)) begin
                    shift_reg = shift_reg >> 1;
                    if (bit_pos == 3'd7) begin
                        r.done     = 1'b1;
                        line_phase = owbm_pkg::PH_IDLE;
                    end else begin
                        bit_pos    = bit_pos + 3'd1;
                        line_phase = owbm_pkg::PH_W_LOW;
                    end
                end
            end
            owbm_pkg::PH_R_LOW: begin
                r.drive_low = 1'b1;
                if (slot_elapsed({4'd0, line_cfg.read_low_time}))
                    line_phase = owbm_pkg::PH_R_WAIT;
            end
            owbm_pkg::PH_R_WAIT: begin
                if (slot_elapsed({4'd0, line_cfg.read_sample_delay}))
                    line_phase = owbm_pkg::PH_R_REC;
            end
            owbm_pkg::PH_R_REC: begin
                // sample on the first released tick of the recovery
                if (slot_timer == 0) shift_reg = {lvl, shift_reg[7:1]};
                if (slot_elapsed(owbm_pkg::READ_REC_TICKS)) begin
                    if (bit_pos == 3'd7) begin
                        r.done       = 1'b1;
                        r.read_valid = 1'b1;
                        r.read_data  = shift_reg;
                        line_phase   = owbm_pkg::PH_IDLE;
                    end else begin
                        bit_pos    = bit_pos + 3'd1;
                        line_phase = owbm_pkg::PH_R_LOW;
                    end
                end
            end
            default: ;
        endcase
        r.busy = (line_phase != owbm_pkg::PH_IDLE);
        return r;
    endfunction

    // driver: offers queued ticks, each followed by a random gap unless in a burst
    t_bus_tick  offer;
    logic [3:0] drv_wait = '0;
    logic       drv_burst = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            drv_wait   <= '0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                tick_results_due.push_back(advance_bus_tick(i_cmd, i_data_byte, i_bus_level));
            end
            if (!i_in_valid || o_in_ready) begin
                if (drv_wait != 0) begin
                    drv_wait   <= drv_wait - 4'd1;
                    i_in_valid <= 1'b0;
                end else if (ticks_to_send.size() != 0) begin
                    offer = ticks_to_send.pop_front();
                    i_cmd       <= offer.cmd;
                    i_data_byte <= offer.data;
                    i_bus_level <= offer.lvl;
                    i_in_valid  <= 1'b1;
                    drv_wait    <= drv_burst ? 4'd0 : 4'($urandom_range(0, 15));
                    if ($urandom_range(0, 63) == 0) drv_burst <= ~drv_burst;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic note_field(input string what, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
            mismatches++;
        end
    endtask

    // monitor: checks each result beat, stalls at random, now and then for a long stretch
    owbm_pkg::t_result owed;
    int                mon_wait = 0;
    int                mon_next;
    logic              mon_burst = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            mon_wait    <= 0;
        end else begin
            mon_next = mon_wait;
            if (o_out_valid && i_out_ready) begin
                if (tick_results_due.size() == 0) begin
                    $display("%0t: result beat with nothing owed", $time);
                    mismatches++;
                end else begin
                    owed = tick_results_due.pop_front();
                    note_field("drive_low", 8'(owed.drive_low), 8'(o_drive_low));
                    note_field("busy", 8'(owed.busy), 8'(o_busy_res));
                    note_field("done", 8'(owed.done), 8'(o_done_res));
                    note_field("presence_fail", 8'(owed.presence_fail), 8'(o_presence_fail));
                    note_field("read_data", owed.read_data, o_read_data);
                    note_field("read_valid", 8'(owed.read_valid), 8'(o_read_valid));
                end
                beats_seen++;
                if (beats_seen % 1500 == 700) mon_next = PRESSURE_HOLD;
                else mon_next = mon_burst ? 0 : $urandom_range(0, 15);
                if ($urandom_range(0, 63) == 0) mon_burst <= ~mon_burst;
            end
            if (mon_next != 0) begin
                i_out_ready <= 1'b0;
                mon_wait    <= mon_next - 1;
            end else begin
                i_out_ready <= 1'b1;
                mon_wait    <= 0;
            end
        end
    end

    // cycles with no beat on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("one_wire_bus_master regression: fail");
        $finish;
    end

    // stimulus helpers
    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_timings(input owbm_pkg::t_cfg c);
        reg_write(owbm_pkg::REG_RESET_LOW, {20'd0, c.reset_low_time});
        reg_write(owbm_pkg::REG_RESET_REC, {24'd0, c.reset_recovery_time});
        reg_write(owbm_pkg::REG_PRES_WAIT, {24'd0, c.presence_wait_limit});
        reg_write(owbm_pkg::REG_PRES_LOW, {24'd0, c.presence_low_limit});
        reg_write(owbm_pkg::REG_WRITE_LOW, {24'd0, c.write_low_time});
        reg_write(owbm_pkg::REG_WRITE_SLOT, {24'd0, c.write_slot_time});
        reg_write(owbm_pkg::REG_READ_LOW, {24'd0, c.read_low_time});
        reg_write(owbm_pkg::REG_READ_SAMPLE, {24'd0, c.read_sample_delay});
        line_cfg = c;
    endtask

    function automatic int slot_ticks(input int dur);
        return (dur == 0) ? 1 : dur;
    endfunction

    task automatic push_tick(input logic [1:0] cmd, input logic [7:0] data, input logic lvl);
        ticks_to_send.push_back(t_bus_tick'{cmd, data, lvl});
        ticks_queued++;
    endtask

    // ticks while an operation runs: commands here must be ignored
    task automatic push_noise(input int n);
        repeat (n) push_tick(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1)));
    endtask

    task automatic issue_cmd(input logic [1:0] cmd, input logic [7:0] data);
        repeat ($urandom_range(0, 2)) push_tick(owbm_pkg::CMD_NONE, 8'($urandom), 1'($urandom));
        push_tick(cmd, data, 1'($urandom));
    endtask

    // reset: presence pulse of lo_ticks after hi_ticks of idle line
    task automatic issue_reset(input int hi_ticks, input int lo_ticks);
        issue_cmd(owbm_pkg::CMD_RESET, 8'($urandom));
        push_noise(slot_ticks(int'(line_cfg.reset_low_time))
                   + slot_ticks(int'(line_cfg.reset_recovery_time)) - 1);
        repeat (hi_ticks) push_tick(owbm_pkg::CMD_NONE, 8'($urandom), 1'b1);
        repeat (lo_ticks) push_tick(owbm_pkg::CMD_NONE, 8'($urandom), 1'b0);
        repeat (lo_ticks == 0 ? int'(line_cfg.presence_wait_limit) + 2 : 2)
            push_tick(owbm_pkg::CMD_NONE, 8'($urandom), 1'b1);
    endtask

    task automatic issue_write(input logic [7:0] data);
        issue_cmd(owbm_pkg::CMD_WRITE, data);
        push_noise(8 * (slot_ticks(int'(line_cfg.write_low_time))
                        + slot_ticks(int'(line_cfg.write_slot_time)) + 5) - 1);
    endtask

    task automatic issue_read();
        issue_cmd(owbm_pkg::CMD_READ, 8'($urandom));
        push_noise(8 * (slot_ticks(int'(line_cfg.read_low_time))
                        + slot_ticks(int'(line_cfg.read_sample_delay)) + 50) - 1);
    endtask

    // wait until every result is in and the line operation has ended
    task automatic settle();
        bit idle;
        idle = 1'b0;
        while (!idle) begin
            do @(negedge i_clk);
            while (ticks_to_send.size() != 0 || i_in_valid || tick_results_due.size() != 0);
            idle = (line_phase == owbm_pkg::PH_IDLE);
            if (!idle) repeat (16) push_tick(owbm_pkg::CMD_NONE, 8'($urandom), 1'b1);
        end
    endtask

    initial begin
        owbm_pkg::t_cfg c;
        int             ops_left;
        int             kind;
        int             hi_ticks;
        int             lo_ticks;

        line_cfg     = STD_TIMINGS;
        line_phase   = owbm_pkg::PH_IDLE;
        slot_timer   = '0;
        presence_run = '0;
        bit_pos      = '0;
        shift_reg    = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // standard timings straight out of reset
        issue_write(8'hA5);
        settle();

        // single-tick timings: a read and each way a reset can end
        apply_timings(ONE_TIMINGS);
        issue_read();
        issue_reset(0, 1);
        issue_reset(2, 0);
        issue_reset(0, 3);
        settle();

        // zero durations act as one tick, zero presence limit fails at once
        apply_timings('0);
        issue_reset(0, 1);
        issue_write(8'h5A);
        settle();

        // longest presence limits; presence pulse overruns its limit
        apply_timings(LIM_TIMINGS);
        issue_reset(20, 256);
        settle();

        // random operations under short random timings
        while (ticks_queued < ITEMS) begin
            c.reset_low_time      = 12'($urandom_range(0, 6));
            c.reset_recovery_time = 8'($urandom_range(0, 4));
            c.presence_wait_limit = 8'($urandom_range(0, 8));
            c.presence_low_limit  = 8'($urandom_range(0, 8));
            c.write_low_time      = 8'($urandom_range(0, 3));
            c.write_slot_time     = 8'($urandom_range(0, 4));
            c.read_low_time       = 8'($urandom_range(0, 3));
            c.read_sample_delay   = 8'($urandom_range(0, 4));
            apply_timings(c);
            ops_left = $urandom_range(4, 8);
            while (ops_left > 0 && ticks_queued < ITEMS) begin
                kind = $urandom_range(0, 19);
                if (kind < 9) begin
                    // mostly a proper presence pulse, else anything the line may do
                    if ($urandom_range(0, 3) != 0) begin
                        hi_ticks = (c.presence_wait_limit == 0) ? 0
                                   : $urandom_range(0, c.presence_wait_limit - 1);
                        lo_ticks = $urandom_range(1, (c.presence_low_limit == 0) ? 1
                                                     : c.presence_low_limit);
                    end else begin
                        hi_ticks = $urandom_range(0, c.presence_wait_limit + 1);
                        lo_ticks = $urandom_range(0, c.presence_low_limit + 1);
                    end
                    issue_reset(hi_ticks, lo_ticks);
                end else if (kind < 16) begin
                    issue_write(8'($urandom_range(0, 255)));
                end else begin
                    issue_read();
                end
                ops_left--;
            end
            settle();
        end

        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("one_wire_bus_master regression: pass");
        end else begin
            $display("one_wire_bus_master regression: fail");
        end
        $finish;
    end

endmodule
